FILE: hdl/mkt_pkg.sv
package mkt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int HD_SLOTS_DEF    = 4;
	localparam int HD_REGS         = 4;
	localparam int MAX_RESULTS     = 16;
	localparam int CNT_W           = $clog2(MAX_RESULTS);

	localparam int FUNC_W   = 3;
	localparam int BUTTON_W = 16;
	localparam int CLIENT_W = 32;
	localparam int MASK_W   = 16;
	localparam int CFG_IW   = $clog2(HD_REGS);
	localparam int CFG_DW   = 16;

	typedef enum logic [FUNC_W-1:0] {
		FN_PRESS    = 3'd0,
		FN_RELEASE  = 3'd1,
		FN_REPEAT   = 3'd2,
		FN_CLICK    = 3'd3,
		FN_MODIFY   = 3'd4,
		FN_UNMODIFY = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [MASK_W-1:0]   mask;
		logic [BUTTON_W-1:0] button;
		logic [CLIENT_W-1:0] client;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef logic [HD_REGS-1:0][BUTTON_W-1:0] hd_regs_t;

	// decoded action
	typedef struct packed {
		logic       act;
		logic [1:0] n_fixed;
		logic       press0;
		logic       press1;
		logic       rep;
		logic       ins;
		logic       ers;
		logic       rel;
		logic       set_b;
		logic       clr_b;
		logic       clr_none;
		logic       emit_scan;
	} op_t;

endpackage

FILE: hdl/mkt_ram.sv
module mkt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/mkt_decode.sv
module mkt_decode #(
	parameter int HD_SLOTS = mkt_pkg::HD_SLOTS_DEF
) (
	input  mkt_pkg::func_t                   func,
	input  logic [mkt_pkg::BUTTON_W-1:0]     button,
	input  logic [mkt_pkg::MASK_W-1:0]       gen,
	input  logic                             lock,
	input  logic [mkt_pkg::MASK_W-1:0]       cur_mask,
	input  mkt_pkg::hd_regs_t                hd_btn,
	output mkt_pkg::op_t                     op
);
	import mkt_pkg::*;

	logic hd;

	always_comb begin
		hd = 1'b0;
		for (int k = 0; k < HD_SLOTS; k++) begin
			hd = hd | ((hd_btn[k] != '0) && (hd_btn[k] == button));
		end
	end

	always_comb begin
		op = '0;
		unique case (func)
			FN_PRESS: begin
				op.act     = 1'b1;
				op.n_fixed = 2'd1;
				op.press0  = 1'b1;
				if (gen != '0) begin
					if (!lock || ((cur_mask & gen) == '0)) begin
						op.ins   = 1'b1;
						op.set_b = 1'b1;
					end else begin
						op.ers   = 1'b1;
						op.clr_b = 1'b1;
					end
				end
			end
			FN_RELEASE: begin
				op.act     = 1'b1;
				op.n_fixed = 2'd1;
				if ((gen != '0) && !lock) begin
					op.rel      = 1'b1;
					op.clr_none = 1'b1;
				end
			end
			FN_REPEAT: begin
				op.act     = 1'b1;
				op.n_fixed = 2'd2;
				op.press1  = 1'b1;
				op.rep     = 1'b1;
			end
			FN_CLICK: begin
				op.act     = 1'b1;
				op.n_fixed = 2'd2;
				op.press0  = 1'b1;
			end
			FN_MODIFY, FN_UNMODIFY: begin
				op.act = 1'b1;
				if (lock) begin
					if (hd) begin
						op.n_fixed = 2'd1;
						op.press0  = (func == FN_MODIFY);
					end else begin
						op.n_fixed = 2'd2;
						op.press0  = 1'b1;
					end
				end else if (func == FN_MODIFY) begin
					op.n_fixed = 2'd1;
					op.press0  = 1'b1;
				end else begin
					op.emit_scan = 1'b1;
				end
				if (func == FN_MODIFY) begin
					op.ins   = 1'b1;
					op.set_b = 1'b1;
				end else begin
					op.ers   = 1'b1;
					op.clr_b = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/mkt_seq.sv
module mkt_seq #(
	parameter int TABLE_DEPTH = mkt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  mkt_pkg::op_t                       op,
	input  logic [mkt_pkg::BUTTON_W-1:0]       button,
	input  logic [mkt_pkg::CLIENT_W-1:0]       client_word,
	input  logic [mkt_pkg::MASK_W-1:0]         gen,
	output logic [mkt_pkg::MASK_W-1:0]         cur_mask,
	output logic                               ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]     ram_waddr,
	output mkt_pkg::entry_t                    ram_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0]     ram_raddr,
	input  mkt_pkg::entry_t                    ram_rdata,
	output logic                               strobe,
	output logic [mkt_pkg::BUTTON_W-1:0]       stroke_button,
	output logic                               stroke_press,
	output logic                               stroke_repeat,
	output logic [mkt_pkg::CLIENT_W-1:0]       stroke_client,
	output logic [mkt_pkg::MASK_W-1:0]         modifier_state,
	output logic                               last_stroke
);
	import mkt_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [MASK_W-1:0]      cur_mask_q;
	op_t                    op_q;
	logic [BUTTON_W-1:0]    btn_q;
	logic [CLIENT_W-1:0]    cli_q;
	logic [MASK_W-1:0]      gen_q;

	logic [IW-1:0] scan_idx_q;
	logic          issue_done_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic          rel_found_q;
	logic [IW-1:0] rel_idx_q;
	logic          other_q;

	logic                hold_q;
	logic [BUTTON_W-1:0] hold_btn_q;
	logic [CLIENT_W-1:0] hold_cli_q;
	logic                cut_q;
	logic [CNT_W-1:0]    emit_cnt_q;
	logic                fix_idx_q;

	logic                strobe_q;
	logic [BUTTON_W-1:0] o_btn_q;
	logic                o_press_q;
	logic                o_rep_q;
	logic [CLIENT_W-1:0] o_cli_q;
	logic [MASK_W-1:0]   o_mask_q;
	logic                o_last_q;

	logic                accept;
	logic                hit;
	logic                cnt_full;
	logic [MASK_W-1:0]   final_mask;
	logic                emit_v;
	logic [BUTTON_W-1:0] emit_btn;
	logic                emit_press;
	logic                emit_rep;
	logic [CLIENT_W-1:0] emit_cli;
	logic [MASK_W-1:0]   emit_mask;
	logic                emit_last;

	assign accept   = start && (state_q == ST_IDLE);
	assign hit      = rd_vld_s1 && valid_q[rd_idx_s1] && (ram_rdata.mask == gen_q);
	assign cnt_full = (emit_cnt_q == CNT_W'(MAX_RESULTS - 1));

	always_comb begin
		if (op_q.set_b) begin
			final_mask = cur_mask_q | gen_q;
		end else if (op_q.clr_b || (op_q.clr_none && !other_q)) begin
			final_mask = cur_mask_q & ~gen_q;
		end else begin
			final_mask = cur_mask_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		busy       = 1'b1;
		ram_raddr  = scan_idx_q;
		ram_we     = 1'b0;
		ram_waddr  = free_idx_q;
		ram_wdata  = '{mask: gen_q, button: btn_q, client: cli_q};
		emit_v     = 1'b0;
		emit_btn   = hold_btn_q;
		emit_press = 1'b0;
		emit_rep   = 1'b0;
		emit_cli   = hold_cli_q;
		emit_mask  = final_mask;
		emit_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && op.act) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (op_q.emit_scan && hit && !cut_q && hold_q) begin
					emit_v    = 1'b1;
					emit_last = cnt_full;
				end
				if (rd_vld_s1 && (rd_idx_s1 == LAST_IDX)) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				ram_we = op_q.ins && free_found_q;
				if (hold_q && !cut_q) begin
					emit_v    = 1'b1;
					emit_last = 1'b1;
				end
				state_d = (op_q.n_fixed != 2'd0) ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				emit_v     = 1'b1;
				emit_btn   = btn_q;
				emit_press = fix_idx_q ? op_q.press1 : op_q.press0;
				emit_rep   = op_q.rep;
				emit_cli   = cli_q;
				emit_mask  = cur_mask_q;
				emit_last  = fix_idx_q || (op_q.n_fixed == 2'd1);
				if (emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// table bookkeeping and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cur_mask_q   <= '0;
			op_q         <= '0;
			scan_idx_q   <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			free_found_q <= 1'b0;
			rel_found_q  <= 1'b0;
			other_q      <= 1'b0;
			hold_q       <= 1'b0;
			cut_q        <= 1'b0;
			emit_cnt_q   <= '0;
			fix_idx_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && !issue_done_q;
			if (accept) begin
				op_q         <= op;
				scan_idx_q   <= '0;
				issue_done_q <= 1'b0;
				free_found_q <= 1'b0;
				rel_found_q  <= 1'b0;
				other_q      <= 1'b0;
				hold_q       <= 1'b0;
				cut_q        <= 1'b0;
				emit_cnt_q   <= '0;
				fix_idx_q    <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (!issue_done_q) begin
					if (scan_idx_q == LAST_IDX) begin
						issue_done_q <= 1'b1;
					end else begin
						scan_idx_q <= scan_idx_q + IW'(1);
					end
				end
				if (rd_vld_s1 && !valid_q[rd_idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (hit) begin
					if (op_q.ers) begin
						valid_q[rd_idx_s1] <= 1'b0;
					end
					if (op_q.rel) begin
						if ((ram_rdata.button == btn_q) && !rel_found_q) begin
							rel_found_q <= 1'b1;
						end else begin
							other_q <= 1'b1;
						end
					end
					if (op_q.emit_scan && !cut_q) begin
						hold_q <= 1'b1;
						if (hold_q) begin
							emit_cnt_q <= emit_cnt_q + CNT_W'(1);
							if (cnt_full) begin
								cut_q <= 1'b1;
							end
						end
					end
				end
			end
			if (state_q == ST_COMMIT) begin
				cur_mask_q <= final_mask;
				if (op_q.ins && free_found_q) begin
					valid_q[free_idx_q] <= 1'b1;
				end
				if (op_q.rel && rel_found_q) begin
					valid_q[rel_idx_q] <= 1'b0;
				end
			end
			if (state_q == ST_EMIT) begin
				fix_idx_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			btn_q <= button;
			cli_q <= client_word;
			gen_q <= gen;
		end
		rd_idx_s1 <= scan_idx_q;
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (!valid_q[rd_idx_s1] && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
			if (hit && op_q.rel && (ram_rdata.button == btn_q) && !rel_found_q) begin
				rel_idx_q <= rd_idx_s1;
			end
			if (hit && op_q.emit_scan && !cut_q) begin
				hold_btn_q <= ram_rdata.button;
				hold_cli_q <= ram_rdata.client;
			end
		end
		o_btn_q   <= emit_btn;
		o_press_q <= emit_press;
		o_rep_q   <= emit_rep;
		o_cli_q   <= emit_cli;
		o_mask_q  <= emit_mask;
		o_last_q  <= emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_v;
		end
	end

	assign cur_mask       = cur_mask_q;
	assign strobe         = strobe_q;
	assign stroke_button  = o_btn_q;
	assign stroke_press   = o_press_q;
	assign stroke_repeat  = o_rep_q;
	assign stroke_client  = o_cli_q;
	assign modifier_state = o_mask_q;
	assign last_stroke    = o_last_q;

endmodule

FILE: hdl/modifier_keystroke_tracker_top.sv
// Modifier keystroke tracker.
// Input: one key action per beat, taken at a clock edge with start high and busy low.
// The fields func, button, client_word, generates_mask and is_lock are sampled then.
// Output: a run of zero to sixteen strokes, one per cycle while strobe is high;
// last_stroke marks the final stroke and modifier_state carries the mask after the action.
// Configuration: cfg_we writes cfg_wdata into half-duplex register cfg_idx at once;
// write only while busy is low and the previous run has drained.
// Timing: every known action runs a scan of the held-key memory, one entry a cycle,
// through a registered read, then a commit state, then an emit state for the fixed
// strokes. An unmodify scan puts out its strokes during the scan and the commit state.
// Unknown func codes run no scan and give no stroke.
// Reset (arst_n low) empties the key table, clears the modifier mask and the
// half-duplex registers; the memory contents are not cleared and need no sweep.
// The receiver cannot stall: each stroke is valid for exactly one cycle.
module modifier_keystroke_tracker_top #(
	parameter int TABLE_DEPTH       = mkt_pkg::TABLE_DEPTH_DEF,
	parameter int HALF_DUPLEX_SLOTS = mkt_pkg::HD_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [mkt_pkg::FUNC_W-1:0]     func,
	input  logic [mkt_pkg::BUTTON_W-1:0]   button,
	input  logic [mkt_pkg::CLIENT_W-1:0]   client_word,
	input  logic [mkt_pkg::MASK_W-1:0]     generates_mask,
	input  logic                           is_lock,
	input  logic                           cfg_we,
	input  logic [mkt_pkg::CFG_IW-1:0]     cfg_idx,
	input  logic [mkt_pkg::CFG_DW-1:0]     cfg_wdata,
	output logic                           strobe,
	output logic [mkt_pkg::BUTTON_W-1:0]   stroke_button,
	output logic                           stroke_press,
	output logic                           stroke_repeat,
	output logic [mkt_pkg::CLIENT_W-1:0]   stroke_client,
	output logic [mkt_pkg::MASK_W-1:0]     modifier_state,
	output logic                           last_stroke
);
	import mkt_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);

	hd_regs_t          hd_q;
	op_t               op;
	logic [MASK_W-1:0] cur_mask;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [IW-1:0]     ram_raddr;
	entry_t            ram_wdata;
	entry_t            ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_q <= '0;
		end else if (cfg_we) begin
			hd_q[cfg_idx] <= BUTTON_W'(cfg_wdata);
		end
	end

	mkt_decode #(
		.HD_SLOTS(HALF_DUPLEX_SLOTS)
	) u_decode (
		.func     (func_t'(func)),
		.button   (button),
		.gen      (generates_mask),
		.lock     (is_lock),
		.cur_mask (cur_mask),
		.hd_btn   (hd_q),
		.op       (op)
	);

	mkt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	mkt_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.button         (button),
		.client_word    (client_word),
		.gen            (generates_mask),
		.cur_mask       (cur_mask),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.strobe         (strobe),
		.stroke_button  (stroke_button),
		.stroke_press   (stroke_press),
		.stroke_repeat  (stroke_repeat),
		.stroke_client  (stroke_client),
		.modifier_state (modifier_state),
		.last_stroke    (last_stroke)
	);

endmodule

FILE: tb/modifier_keystroke_tracker_top_tb.sv
`timescale 1ns / 100ps

module modifier_keystroke_tracker_top_tb;
	import mkt_pkg::*;

	localparam int DEPTH       = TABLE_DEPTH_DEF;
	localparam int HD_SLOTS    = HD_SLOTS_DEF;
	localparam int SETTLE      = 2 * (TABLE_DEPTH_DEF + 3 + MAX_RESULTS);
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [FUNC_W-1:0]   fcode;
		logic [BUTTON_W-1:0] button;
		logic [CLIENT_W-1:0] client;
		logic [MASK_W-1:0]   mask;
		logic                lock;
	} key_action_t;

	typedef struct packed {
		logic [BUTTON_W-1:0] button;
		logic                press;
		logic                rep;
		logic [CLIENT_W-1:0] client;
		logic [MASK_W-1:0]   mods;
		logic                last;
	} stroke_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [FUNC_W-1:0]   func = '0;
	logic [BUTTON_W-1:0] button = '0;
	logic [CLIENT_W-1:0] client_word = '0;
	logic [MASK_W-1:0]   generates_mask = '0;
	logic                is_lock = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_IW-1:0]   cfg_idx = '0;
	logic [CFG_DW-1:0]   cfg_wdata = '0;
	logic                strobe;
	logic [BUTTON_W-1:0] stroke_button;
	logic                stroke_press;
	logic                stroke_repeat;
	logic [CLIENT_W-1:0] stroke_client;
	logic [MASK_W-1:0]   modifier_state;
	logic                last_stroke;

	modifier_keystroke_tracker_top DUT (.*);

	// pending key actions and expected strokes
	key_action_t action_q[$];
	stroke_t     stroke_q[$];
	stroke_t     run_q[$];
	int          queued = 0;
	int          gap_left = 0;
	int          err_cnt = 0;
	int          cycle_cnt = 0;

	// tracker shadow state
	logic [BUTTON_W-1:0] hd_shadow [HD_REGS];
	logic [MASK_W-1:0]   held_mask [DEPTH];
	logic [BUTTON_W-1:0] held_button [DEPTH];
	logic [CLIENT_W-1:0] held_client [DEPTH];
	logic                held_valid [DEPTH];
	logic [MASK_W-1:0]   cur_mods = '0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			held_valid[i] = 1'b0;
			held_mask[i] = '0;
			held_button[i] = '0;
			held_client[i] = '0;
		end
		for (int i = 0; i < HD_REGS; i++) hd_shadow[i] = '0;
	end

	task automatic add_stroke(input logic [BUTTON_W-1:0] b, input logic p, input logic r,
			input logic [CLIENT_W-1:0] c);
		stroke_t s;
		s = '0;
		s.button = b;
		s.press = p;
		s.rep = r;
		s.client = c;
		if (run_q.size() < MAX_RESULTS) run_q = {run_q, s};
	endtask

	task automatic insert_held(input logic [MASK_W-1:0] m, input logic [BUTTON_W-1:0] b,
			input logic [CLIENT_W-1:0] c);
		bit done;
		done = 0;
		for (int i = 0; i < DEPTH; i++) begin
			if (!done && !held_valid[i]) begin
				held_valid[i] = 1'b1;
				held_mask[i] = m;
				held_button[i] = b;
				held_client[i] = c;
				done = 1;
			end
		end
	endtask

	task automatic erase_held(input logic [MASK_W-1:0] m);
		for (int i = 0; i < DEPTH; i++)
			if (held_valid[i] && held_mask[i] == m) held_valid[i] = 1'b0;
	endtask

	task automatic predict_strokes(input key_action_t a);
		bit hit;
		bit hd;
		stroke_t s;
		run_q = {};
		case (a.fcode)
			FN_PRESS: begin
				add_stroke(a.button, 1'b1, 1'b0, a.client);
				if (a.mask != 0) begin
					if (!a.lock || (cur_mods & a.mask) == 0) begin
						insert_held(a.mask, a.button, a.client);
						cur_mods = cur_mods | a.mask;
					end else begin
						erase_held(a.mask);
						cur_mods = cur_mods & ~a.mask;
					end
				end
			end
			FN_RELEASE: begin
				add_stroke(a.button, 1'b0, 1'b0, a.client);
				if (a.mask != 0 && !a.lock) begin
					hit = 0;
					for (int i = 0; i < DEPTH; i++) begin
						if (!hit && held_valid[i] && held_mask[i] == a.mask &&
								held_button[i] == a.button) begin
							held_valid[i] = 1'b0;
							hit = 1;
						end
					end
					hit = 0;
					for (int i = 0; i < DEPTH; i++)
						if (held_valid[i] && held_mask[i] == a.mask) hit = 1;
					if (!hit) cur_mods = cur_mods & ~a.mask;
				end
			end
			FN_REPEAT: begin
				add_stroke(a.button, 1'b0, 1'b1, a.client);
				add_stroke(a.button, 1'b1, 1'b1, a.client);
			end
			FN_CLICK: begin
				add_stroke(a.button, 1'b1, 1'b0, a.client);
				add_stroke(a.button, 1'b0, 1'b0, a.client);
			end
			FN_MODIFY, FN_UNMODIFY: begin
				if (a.lock) begin
					hd = 0;
					for (int i = 0; i < HD_SLOTS && i < HD_REGS; i++)
						if (hd_shadow[i] != 0 && hd_shadow[i] == a.button) hd = 1;
					if (hd) begin
						add_stroke(a.button, a.fcode == FN_MODIFY, 1'b0, a.client);
					end else begin
						add_stroke(a.button, 1'b1, 1'b0, a.client);
						add_stroke(a.button, 1'b0, 1'b0, a.client);
					end
				end else if (a.fcode == FN_MODIFY) begin
					add_stroke(a.button, 1'b1, 1'b0, a.client);
				end else begin
					for (int i = 0; i < DEPTH; i++)
						if (held_valid[i] && held_mask[i] == a.mask)
							add_stroke(held_button[i], 1'b0, 1'b0, held_client[i]);
				end
				if (a.fcode == FN_MODIFY) begin
					insert_held(a.mask, a.button, a.client);
					cur_mods = cur_mods | a.mask;
				end else begin
					erase_held(a.mask);
					cur_mods = cur_mods & ~a.mask;
				end
			end
			default: ;
		endcase
		for (int k = 0; k < run_q.size(); k++) begin
			s = run_q[k];
			s.mods = cur_mods;
			s.last = (k == run_q.size() - 1);
			stroke_q = {stroke_q, s};
		end
	endtask

	// driver: start held until accepted, random gaps between beats
	always @(posedge clk) begin : drv_blk
		key_action_t nx;
		key_action_t cur;
		int r;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				cur.fcode = func;
				cur.button = button;
				cur.client = client_word;
				cur.mask = generates_mask;
				cur.lock = is_lock;
				predict_strokes(cur);
			end
			if (!start || !busy) begin
				if (gap_left != 0 || action_q.size() == 0) begin
					start <= 1'b0;
					func <= FUNC_W'($urandom);
					button <= BUTTON_W'($urandom);
					client_word <= $urandom;
					generates_mask <= MASK_W'($urandom);
					is_lock <= 1'($urandom);
					if (gap_left != 0) gap_left <= gap_left - 1;
				end else begin
					nx = action_q.pop_front();
					start <= 1'b1;
					func <= nx.fcode;
					button <= nx.button;
					client_word <= nx.client;
					generates_mask <= nx.mask;
					is_lock <= nx.lock;
					r = $urandom_range(0, 99);
					if (r < 40) gap_left <= 0;
					else if (r < 80) gap_left <= $urandom_range(1, 25);
					else if (r < 95) gap_left <= $urandom_range(26, 60);
					else gap_left <= $urandom_range(100, 300);
				end
			end
		end
	end

	task automatic flag_mismatch(input string msg);
		if (err_cnt < 10) $display("%s", msg);
		err_cnt++;
	endtask

	always @(posedge clk) begin : mon_blk
		stroke_t e;
		if (arst_n && strobe) begin
			if (stroke_q.size() == 0) begin
				flag_mismatch($sformatf({"unexpected stroke btn %h press %b rep %b cli %h ",
					"mods %h last %b"},
					stroke_button, stroke_press, stroke_repeat, stroke_client,
					modifier_state, last_stroke));
			end else begin
				e = stroke_q.pop_front();
				if (stroke_button !== e.button || stroke_press !== e.press ||
						stroke_repeat !== e.rep || stroke_client !== e.client ||
						modifier_state !== e.mods || last_stroke !== e.last)
					flag_mismatch($sformatf({"stroke mismatch: exp btn %h press %b rep %b cli %h ",
						"mods %h last %b, got btn %h press %b rep %b cli %h mods %h last %b"},
						e.button, e.press, e.rep, e.client, e.mods, e.last,
						stroke_button, stroke_press, stroke_repeat, stroke_client,
						modifier_state, last_stroke));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("modifier_keystroke_tracker_top_tb: FAIL");
			$finish;
		end
	end

	task automatic add_action(input logic [FUNC_W-1:0] f, input logic [BUTTON_W-1:0] b,
			input logic [CLIENT_W-1:0] c, input logic [MASK_W-1:0] m, input logic l);
		key_action_t a;
		a.fcode = f;
		a.button = b;
		a.client = c;
		a.mask = m;
		a.lock = l;
		action_q = {action_q, a};
		queued++;
	endtask

	function automatic logic [MASK_W-1:0] pick_mod_mask();
		logic [MASK_W-1:0] pool [8] = '{16'h0001, 16'h0002, 16'h0004, 16'h0008,
			16'h0010, 16'h0020, 16'h8000, 16'h0003};
		return pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [MASK_W-1:0] pick_lock_mask();
		logic [MASK_W-1:0] pool [4] = '{16'h0100, 16'h0200, 16'h0400, 16'h4000};
		return pool[$urandom_range(0, 3)];
	endfunction

	function automatic logic [BUTTON_W-1:0] pick_key_btn();
		logic [BUTTON_W-1:0] pool [8] = '{16'h0001, 16'h0002, 16'h0003, 16'h0004,
			16'h0005, 16'h0006, 16'hFFFF, 16'h8000};
		return pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [BUTTON_W-1:0] pick_lock_btn();
		logic [BUTTON_W-1:0] pool [6] = '{16'h0039, 16'h003A, 16'h003B, 16'hFFFF,
			16'h0000, 16'h8001};
		return pool[$urandom_range(0, 5)];
	endfunction

	// ordinary non-modifier key beat
	task automatic push_plain();
		logic [FUNC_W-1:0] f;
		f = FUNC_W'($urandom_range(FN_PRESS, FN_CLICK));
		add_action(f, BUTTON_W'($urandom), $urandom, '0, 1'($urandom));
	endtask

	task automatic add_sequence(input int sel);
		logic [MASK_W-1:0]   m;
		logic [BUTTON_W-1:0] b1;
		logic [BUTTON_W-1:0] b2;
		logic                lk;
		int                  n;
		if (sel < 25) begin
			m = pick_mod_mask();
			b1 = pick_key_btn();
			add_action(FN_PRESS, b1, $urandom, m, 1'b0);
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) push_plain();
			add_action(FN_RELEASE, b1, $urandom, m, 1'b0);
		end else if (sel < 40) begin
			m = pick_mod_mask();
			b1 = pick_key_btn();
			b2 = pick_key_btn();
			add_action(FN_PRESS, b1, $urandom, m, 1'b0);
			add_action(FN_PRESS, b2, $urandom, m, 1'b0);
			if ($urandom_range(0, 1)) push_plain();
			case ($urandom_range(0, 2))
				0: begin
					add_action(FN_RELEASE, b1, $urandom, m, 1'b0);
					add_action(FN_RELEASE, b2, $urandom, m, 1'b0);
				end
				1: begin
					add_action(FN_RELEASE, b2, $urandom, m, 1'b0);
					add_action(FN_RELEASE, b1, $urandom, m, 1'b0);
				end
				default: add_action(FN_RELEASE, b1, $urandom, m, 1'b0);
			endcase
		end else if (sel < 50) begin
			m = pick_lock_mask();
			b1 = pick_lock_btn();
			add_action(FN_PRESS, b1, $urandom, m, 1'b1);
			if ($urandom_range(0, 1)) add_action(FN_RELEASE, b1, $urandom, m, 1'b1);
		end else if (sel < 65) begin
			lk = 1'($urandom_range(0, 1));
			m = lk ? pick_lock_mask() : pick_mod_mask();
			b1 = lk ? pick_lock_btn() : pick_key_btn();
			add_action(FN_MODIFY, b1, $urandom, m, lk);
			n = $urandom_range(0, 2);
			for (int i = 0; i < n; i++) push_plain();
			add_action(FN_UNMODIFY, b1, $urandom, m, lk);
		end else if (sel < 70) begin
			// press ten to eighteen keys on one mask, which can overfill the table, then release everything with one unmodify
			m = pick_mod_mask();
			n = $urandom_range(10, 18);
			for (int i = 0; i < n; i++) add_action(FN_PRESS, pick_key_btn(), $urandom, m, 1'b0);
			add_action(FN_UNMODIFY, BUTTON_W'($urandom), $urandom, m, 1'b0);
		end else if (sel < 90) begin
			add_action(FUNC_W'($urandom_range(0, 7)), BUTTON_W'($urandom), $urandom,
				MASK_W'($urandom), 1'($urandom));
		end else begin
			case ($urandom_range(0, 3))
				0: add_action(FN_RELEASE, pick_key_btn(), $urandom, pick_mod_mask(), 1'b0);
				1: add_action(FN_UNMODIFY, BUTTON_W'($urandom), $urandom, pick_mod_mask(),
					1'b0);
				2: add_action(FN_MODIFY, pick_key_btn(), $urandom, pick_mod_mask(), 1'b0);
				default: add_action(FN_PRESS, pick_key_btn(), $urandom, MASK_W'($urandom),
					1'b0);
			endcase
		end
	endtask

	task automatic write_hd_regs(input hd_regs_t v);
		for (int i = 0; i < HD_REGS; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= CFG_IW'(i);
			cfg_wdata <= v[i];
			hd_shadow[i] = v[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (action_q.size() != 0 || start || busy || stroke_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stim_blk
		hd_regs_t cv;
		int tgt;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset config: an all-zero slot must not match button zero
		add_action(FN_MODIFY, 16'h0000, 32'h0000_0000, 16'h0100, 1'b1);
		add_action(FN_UNMODIFY, 16'h0000, 32'h1234_5678, 16'h0100, 1'b1);
		add_action(3'd6, 16'h0041, 32'hA5A5_A5A5, 16'h0001, 1'b0);
		add_action(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		wait_drained();

		cv[0] = 16'hFFFF;
		cv[1] = 16'h0039;
		cv[2] = 16'h003A;
		cv[3] = 16'h0000;
		write_hd_regs(cv);
		add_action(FN_PRESS, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		add_action(FN_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		add_action(FN_PRESS, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
		add_action(FN_RELEASE, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
		add_action(FN_REPEAT, 16'h0041, 32'h0000_0041, 16'h0000, 1'b0);
		add_action(FN_CLICK, 16'h0041, 32'h0000_0042, 16'h0000, 1'b0);
		// lock toggles on, then off
		add_action(FN_PRESS, 16'h003A, 32'h0000_003A, 16'h0200, 1'b1);
		add_action(FN_PRESS, 16'h003A, 32'h0000_003B, 16'h0200, 1'b1);
		add_action(FN_RELEASE, 16'h003A, 32'h0000_003C, 16'h0200, 1'b1);
		// half-duplex lock: single press, single release
		add_action(FN_MODIFY, 16'h0039, 32'h0000_0039, 16'h0100, 1'b1);
		add_action(FN_UNMODIFY, 16'hFFFF, 32'h0000_FFFF, 16'h0100, 1'b1);
		add_action(FN_MODIFY, 16'h0010, 32'hCAFE_0010, 16'h0001, 1'b0);
		add_action(FN_PRESS, 16'h0011, 32'hCAFE_0011, 16'h0001, 1'b0);
		add_action(FN_RELEASE, 16'h0011, 32'hCAFE_0012, 16'h0001, 1'b0);
		add_action(FN_UNMODIFY, 16'h0077, 32'hCAFE_0077, 16'h0001, 1'b0);
		// empty run
		add_action(FN_UNMODIFY, 16'h0077, 32'hCAFE_0078, 16'h0001, 1'b0);
		add_action(FN_MODIFY, 16'h0020, 32'h0000_0020, 16'h0000, 1'b0);
		add_action(FN_UNMODIFY, 16'h0021, 32'h0000_0021, 16'h0000, 1'b0);
		// exact mask match only
		add_action(FN_PRESS, 16'h0005, 32'h0000_0005, 16'h0003, 1'b0);
		add_action(FN_UNMODIFY, 16'h0006, 32'h0000_0006, 16'h0001, 1'b0);
		add_action(FN_UNMODIFY, 16'h0007, 32'h0000_0007, 16'h0003, 1'b0);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < HD_REGS; i++) begin
				if (ph == 0) cv[i] = 16'hFFFF;
				else if (ph == 3) cv[i] = 16'h0000;
				else cv[i] = pick_lock_btn();
			end
			write_hd_regs(cv);
			if (ph == 0) add_sequence(67);
			tgt = queued + 60;
			while (queued < tgt) add_sequence($urandom_range(0, 99));
			wait_drained();
		end

		if (err_cnt == 0) begin
			$display("modifier_keystroke_tracker_top_tb: PASS");
		end else begin
			$display("modifier_keystroke_tracker_top_tb: FAIL");
		end
		$finish;
	end

endmodule
